// ===== hw/rtl/triangle_unit_normal_assert.svh =====
// Assertion helpers for the checker file.
`ifndef TRIANGLE_UNIT_NORMAL_ASSERT_SVH
`define TRIANGLE_UNIT_NORMAL_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define TUN_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Condition that must never be seen outside reset.
`define TUN_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ===== hw/rtl/tun_pkg.sv =====
`default_nettype none

package tun_pkg;

  // The largest normalized magnitude sits in [2^30, 2^31).
  localparam int NORM_TOP = 31;
  localparam int MAG_W    = 31;
  localparam int SUM_W    = 64;
  localparam int ROOT_W   = 32;

  typedef struct packed {
    logic       valid;
    logic       degen;
    logic [2:0] neg;
  } tun_ctx_t;

endpackage

`default_nettype wire

// ===== hw/rtl/triangle_unit_normal.sv =====
// Face-normal unit: takes one triangle per item (three vertices, signed
// Q16.8) and returns the unit vector -(e1 x e2)/|e1 x e2| in signed
// Q1.NORMAL_FRAC_BITS, with degenerate_o set and all components zero when
// the cross product vanishes. An item is taken at every clock edge where
// start is high; busy is always low, so one item per cycle is sustained.
// Each result is marked by valid_o for one cycle, in item order. The
// receiver cannot stall the block: whoever consumes results must take them
// in the cycle they show. The pipeline is a chain of 32 square-root
// cells (one root bit each) and NORMAL_FRAC_BITS + 1 divider cells (one
// quotient bit each), plus ten stages for edges, products, cross, sign and
// magnitude, leading one, normalize, squares, sum, divide setup and output.
`default_nettype none

module triangle_unit_normal
  import tun_pkg::*;
#(
  parameter int COORD_WIDTH      = 24,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic signed [COORD_WIDTH-1:0]   v0_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]   v0_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]   v0_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]   v1_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]   v1_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]   v1_z_i,
  input  wire logic signed [COORD_WIDTH-1:0]   v2_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]   v2_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]   v2_z_i,
  output logic                                 valid_o,
  output logic signed [NORMAL_FRAC_BITS+1:0]   normal_x_o,
  output logic signed [NORMAL_FRAC_BITS+1:0]   normal_y_o,
  output logic signed [NORMAL_FRAC_BITS+1:0]   normal_z_o,
  output logic                                 degenerate_o
);

  localparam int CW  = COORD_WIDTH;
  localparam int F   = NORMAL_FRAC_BITS;
  localparam int EW  = CW + 1;          // edge width
  localparam int PW  = 2 * EW;          // product width
  localparam int CXW = PW + 1;          // signed cross component
  localparam int MW  = PW;              // cross magnitude
  localparam int LW  = $clog2(MW + 1);  // bit length of a magnitude
  localparam int QW  = F + 1;           // quotient bits
  localparam int OW  = F + 2;           // output width
  localparam int NW  = F + 34;          // dividend width
  localparam int DW  = ROOT_W + 1;      // divisor 2R

  // Fully pipelined, never stalls.
  assign busy = 1'b0;

  // ---------------------------------------------------------------- edges
  logic                  v1_q;
  logic signed [EW-1:0]  e_q [6];

  always_ff @(posedge clk_i) begin
    e_q[0] <= {v1_x_i[CW-1], v1_x_i} - {v0_x_i[CW-1], v0_x_i};
    e_q[1] <= {v1_y_i[CW-1], v1_y_i} - {v0_y_i[CW-1], v0_y_i};
    e_q[2] <= {v1_z_i[CW-1], v1_z_i} - {v0_z_i[CW-1], v0_z_i};
    e_q[3] <= {v2_x_i[CW-1], v2_x_i} - {v0_x_i[CW-1], v0_x_i};
    e_q[4] <= {v2_y_i[CW-1], v2_y_i} - {v0_y_i[CW-1], v0_y_i};
    e_q[5] <= {v2_z_i[CW-1], v2_z_i} - {v0_z_i[CW-1], v0_z_i};
  end

  // ------------------------------------------------------------- products
  // Pairs: (ay*bz, az*by), (az*bx, ax*bz), (ax*by, ay*bx).
  logic                  v2_q;
  logic signed [PW-1:0]  prod_q [6];

  always_ff @(posedge clk_i) begin
    prod_q[0] <= e_q[1] * e_q[5];
    prod_q[1] <= e_q[2] * e_q[4];
    prod_q[2] <= e_q[2] * e_q[3];
    prod_q[3] <= e_q[0] * e_q[5];
    prod_q[4] <= e_q[0] * e_q[4];
    prod_q[5] <= e_q[1] * e_q[3];
  end

  // ---------------------------------------------------------------- cross
  logic                  v3_q;
  logic signed [CXW-1:0] cx_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      cx_q[i] <= prod_q[2*i] - prod_q[2*i+1];
    end
  end

  // ------------------------------------------------------ sign/magnitude
  logic                  v4_q;
  logic [MW-1:0]         mag4_q [3];
  logic [2:0]            neg4_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      mag4_q[i] <= cx_q[i][CXW-1] ? MW'(-cx_q[i]) : MW'(cx_q[i]);
      neg4_q[i] <= cx_q[i][CXW-1];
    end
  end

  // ------------------------------------------------------ leading one
  // Bit length of the largest magnitude equals that of the OR of all three.
  logic [MW-1:0]         or_w;
  logic [LW-1:0]         lmax_d;
  tun_ctx_t              ctx5_q;
  logic [LW-1:0]         lmax5_q;
  logic [MW-1:0]         mag5_q [3];

  always_comb begin
    or_w   = mag4_q[0] | mag4_q[1] | mag4_q[2];
    lmax_d = '0;
    for (int b = 0; b < MW; b++) begin
      if (or_w[b]) begin
        lmax_d = LW'(b + 1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lmax5_q <= lmax_d;
    mag5_q  <= mag4_q;
  end

  // ------------------------------------------------------------ normalize
  // Common shift puts the top magnitude in [2^30, 2^31); right shift truncates.
  logic [MW+MAG_W-1:0]   wide [3];
  tun_ctx_t              ctx6_q;
  logic [2:0][MAG_W-1:0] m6_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (int'(lmax5_q) <= NORM_TOP) begin
        wide[i] = {MAG_W'(0), mag5_q[i]} << (NORM_TOP - int'(lmax5_q));
      end else begin
        wide[i] = {MAG_W'(0), mag5_q[i]} >> (int'(lmax5_q) - NORM_TOP);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      m6_q[i] <= wide[i][MAG_W-1:0];
    end
  end

  // -------------------------------------------------------------- squares
  tun_ctx_t              ctx7_q;
  logic [2:0][MAG_W-1:0] m7_q;
  logic [2*MAG_W-1:0]    sq7_q [3];

  always_ff @(posedge clk_i) begin
    m7_q <= m6_q;
    for (int i = 0; i < 3; i++) begin
      sq7_q[i] <= {MAG_W'(0), m6_q[i]} * {MAG_W'(0), m6_q[i]};
    end
  end

  // ------------------------------------------------------------------ sum
  tun_ctx_t              ctx8_q;
  logic [2:0][MAG_W-1:0] m8_q;
  logic [SUM_W-1:0]      sum8_q;

  always_ff @(posedge clk_i) begin
    m8_q   <= m7_q;
    sum8_q <= SUM_W'(sq7_q[0]) + SUM_W'(sq7_q[1]) + SUM_W'(sq7_q[2]);
  end

  // Control of the front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      ctx5_q <= '0;
      ctx6_q <= '0;
      ctx7_q <= '0;
      ctx8_q <= '0;
    end else begin
      v1_q         <= start;
      v2_q         <= v1_q;
      v3_q         <= v2_q;
      v4_q         <= v3_q;
      ctx5_q.valid <= v4_q;
      ctx5_q.degen <= (or_w == '0);
      ctx5_q.neg   <= neg4_q;
      ctx6_q       <= ctx5_q;
      ctx7_q       <= ctx6_q;
      ctx8_q       <= ctx7_q;
    end
  end

  // ------------------------------------------------------ square-root row
  tun_ctx_t              sq_ctx  [ROOT_W+1];
  logic [SUM_W-1:0]      sq_s    [ROOT_W+1];
  logic [ROOT_W+1:0]     sq_rem  [ROOT_W+1];
  logic [ROOT_W-1:0]     sq_root [ROOT_W+1];
  logic [2:0][MAG_W-1:0] sq_m    [ROOT_W+1];

  assign sq_ctx[0]  = ctx8_q;
  assign sq_s[0]    = sum8_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sq_m[0]    = m8_q;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    tun_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctx_i  (sq_ctx[k]),
      .s_i    (sq_s[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .m_i    (sq_m[k]),
      .ctx_o  (sq_ctx[k+1]),
      .s_o    (sq_s[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1]),
      .m_o    (sq_m[k+1])
    );
  end

  // ---------------------------------------------------------- divide setup
  // q = floor((2*(m << F) + R) / (2R)): dividend (m << (F+1)) + R, divisor 2R.
  tun_ctx_t              dv_ctx [QW+1];
  logic [DW-1:0]         dv_d   [QW+1];
  logic [2:0][NW-1:0]    dv_rem [QW+1];
  logic [2:0][QW-1:0]    dv_q   [QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_ctx[0] <= '0;
    end else begin
      dv_ctx[0] <= sq_ctx[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_d[0] <= {sq_root[ROOT_W], 1'b0};
    dv_q[0] <= '0;
    for (int i = 0; i < 3; i++) begin
      dv_rem[0][i] <= NW'({sq_m[ROOT_W][i], {(F+1){1'b0}}}) + NW'(sq_root[ROOT_W]);
    end
  end

  // --------------------------------------------------------- divider row
  for (genvar k = 0; k < QW; k++) begin : g_div
    tun_div_cell #(
      .FRAC (F),
      .BIT  (QW - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctx_i  (dv_ctx[k]),
      .d_i    (dv_d[k]),
      .rem_i  (dv_rem[k]),
      .q_i    (dv_q[k]),
      .ctx_o  (dv_ctx[k+1]),
      .d_o    (dv_d[k+1]),
      .rem_o  (dv_rem[k+1]),
      .q_o    (dv_q[k+1])
    );
  end

  // --------------------------------------------------------------- output
  localparam logic [QW-1:0] UNIT = QW'(1) << F;

  logic [QW-1:0] qs   [3];
  logic [OW-1:0] res  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qs[i] = (dv_q[QW][i] > UNIT) ? UNIT : dv_q[QW][i];
      if (dv_ctx[QW].degen) begin
        res[i] = '0;
      end else if (dv_ctx[QW].neg[i]) begin
        res[i] = {1'b0, qs[i]};
      end else begin
        res[i] = -{1'b0, qs[i]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= dv_ctx[QW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    normal_x_o   <= res[0];
    normal_y_o   <= res[1];
    normal_z_o   <= res[2];
    degenerate_o <= dv_ctx[QW].degen;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tun_sqrt_cell.sv =====
`default_nettype none

// One digit of the integer square root: two radicand bits in, one root bit out.
module tun_sqrt_cell
  import tun_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire tun_ctx_t                   ctx_i,
  input  wire logic [SUM_W-1:0]           s_i,
  input  wire logic [ROOT_W+1:0]          rem_i,
  input  wire logic [ROOT_W-1:0]          root_i,
  input  wire logic [2:0][MAG_W-1:0]      m_i,
  output tun_ctx_t                        ctx_o,
  output logic [SUM_W-1:0]                s_o,
  output logic [ROOT_W+1:0]               rem_o,
  output logic [ROOT_W-1:0]               root_o,
  output logic [2:0][MAG_W-1:0]           m_o
);

  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              ge;

  always_comb begin
    rem_sh = {rem_i[ROOT_W-1:0], s_i[SUM_W-1 -: 2]};
    trial  = {root_i, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_o <= '0;
    end else begin
      ctx_o <= ctx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s_o    <= {s_i[SUM_W-3:0], 2'b00};
    rem_o  <= ge ? (rem_sh - trial) : rem_sh;
    root_o <= {root_i[ROOT_W-2:0], ge};
    m_o    <= m_i;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tun_div_cell.sv =====
`default_nettype none

// One quotient bit of a restoring divide, three lanes sharing one divisor.
module tun_div_cell
  import tun_pkg::*;
#(
  parameter int FRAC = 14,
  parameter int BIT  = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tun_ctx_t                      ctx_i,
  input  wire logic [ROOT_W:0]               d_i,
  input  wire logic [2:0][FRAC+33:0]         rem_i,
  input  wire logic [2:0][FRAC:0]            q_i,
  output tun_ctx_t                           ctx_o,
  output logic [ROOT_W:0]                    d_o,
  output logic [2:0][FRAC+33:0]              rem_o,
  output logic [2:0][FRAC:0]                 q_o
);

  localparam int NW = FRAC + 34;
  localparam int QW = FRAC + 1;

  logic [NW-1:0]         dsh;
  logic [2:0]            ge;
  logic [2:0][NW-1:0]    rem_d;
  logic [2:0][QW-1:0]    q_d;

  always_comb begin
    dsh = NW'(d_i) << BIT;
    for (int i = 0; i < 3; i++) begin
      ge[i]    = (rem_i[i] >= dsh);
      rem_d[i] = ge[i] ? (rem_i[i] - dsh) : rem_i[i];
      q_d[i]   = {q_i[i][QW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctx_o <= '0;
    end else begin
      ctx_o <= ctx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    d_o   <= d_i;
    rem_o <= rem_d;
    q_o   <= q_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tun_checker.sv =====
`default_nettype none

`include "triangle_unit_normal_assert.svh"

module tun_checker #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            valid_o,
  input wire logic signed [NORMAL_FRAC_BITS+1:0] normal_x_o,
  input wire logic signed [NORMAL_FRAC_BITS+1:0] normal_y_o,
  input wire logic signed [NORMAL_FRAC_BITS+1:0] normal_z_o,
  input wire logic                            degenerate_o
);

  localparam int LAT = 43 + NORMAL_FRAC_BITS;
  localparam int OW  = NORMAL_FRAC_BITS + 2;
  localparam logic signed [OW-1:0] UNIT_P = OW'(1) << NORMAL_FRAC_BITS;
  localparam logic signed [OW-1:0] UNIT_N = -UNIT_P;

  `TUN_ASSERT_NEVER(a_no_stall, busy)
  `TUN_ASSERT_IMPL(a_fixed_latency, valid_o, $past(start, LAT))
  `TUN_ASSERT_IMPL(a_degen_zero, valid_o && degenerate_o,
                   normal_x_o == '0 && normal_y_o == '0 && normal_z_o == '0)
  `TUN_ASSERT_IMPL(a_nonzero_normal, valid_o && !degenerate_o,
                   normal_x_o != '0 || normal_y_o != '0 || normal_z_o != '0)
  `TUN_ASSERT_IMPL(a_unit_range, valid_o,
                   normal_x_o <= UNIT_P && normal_x_o >= UNIT_N &&
                   normal_y_o <= UNIT_P && normal_y_o >= UNIT_N &&
                   normal_z_o <= UNIT_P && normal_z_o >= UNIT_N)

endmodule

bind triangle_unit_normal tun_checker #(
  .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
) u_tun_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .valid_o      (valid_o),
  .normal_x_o   (normal_x_o),
  .normal_y_o   (normal_y_o),
  .normal_z_o   (normal_z_o),
  .degenerate_o (degenerate_o)
);

`default_nettype wire

// ===== tb/sv/tb_triangle_unit_normal.sv =====
`timescale 1ns / 100ps

module tb_triangle_unit_normal;
  import tun_pkg::*;

  localparam int CW    = 24;
  localparam int FRAC  = 14;
  localparam int OW    = FRAC + 2;
  localparam int UNIT  = 1 << FRAC;
  localparam int N_RAND_PER_PHASE = 390;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [OW-1:0] comp_t;

  typedef struct {
    coord_t p [9];
  } tri_t;

  typedef struct packed {
    comp_t nx;
    comp_t ny;
    comp_t nz;
    logic  degen;
  } normal_t;

  // directed row: triangle plus optional hand-typed expectation
  typedef struct {
    tri_t    t;
    bit      has_exp;
    normal_t e;
  } row_t;

  logic  clk_i = 0;
  logic  rst_ni = 0;
  logic  start = 0;
  logic  busy;
  coord_t vin [9];
  logic  valid_o;
  comp_t normal_x_o, normal_y_o, normal_z_o;
  logic  degenerate_o;

  normal_t expected_normals[$];
  int    errors = 0;
  int    n_items = 0;
  int    n_results = 0;
  int    n_degen = 0;
  int    sender_idle_pct = 0;
  bit    item_taken;

  initial for (int i = 0; i < 9; i++) vin[i] = '0;

  triangle_unit_normal uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .v0_x_i(vin[0]), .v0_y_i(vin[1]), .v0_z_i(vin[2]),
    .v1_x_i(vin[3]), .v1_y_i(vin[4]), .v1_z_i(vin[5]),
    .v2_x_i(vin[6]), .v2_y_i(vin[7]), .v2_z_i(vin[8]),
    .valid_o(valid_o), .normal_x_o(normal_x_o), .normal_y_o(normal_y_o),
    .normal_z_o(normal_z_o), .degenerate_o(degenerate_o)
  );

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  // bit-exact integer square root (floor)
  function automatic bit [63:0] isqrt(bit [63:0] s);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // -c/|c| in Q1.FRAC, c = (p1-p0) x (p2-p0)
  function automatic normal_t face_normal(tri_t t);
    longint ax, ay, az, bx, by, bz;
    longint c [3];
    bit [63:0] m [3];
    bit [63:0] s, r, q, x;
    comp_t o [3];
    int lmax, sh;
    normal_t n;
    ax = longint'(t.p[3]) - longint'(t.p[0]);
    ay = longint'(t.p[4]) - longint'(t.p[1]);
    az = longint'(t.p[5]) - longint'(t.p[2]);
    bx = longint'(t.p[6]) - longint'(t.p[0]);
    by = longint'(t.p[7]) - longint'(t.p[1]);
    bz = longint'(t.p[8]) - longint'(t.p[2]);
    c[0] = ay * bz - az * by;
    c[1] = az * bx - ax * bz;
    c[2] = ax * by - ay * bx;
    lmax = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (c[i] < 0) ? -c[i] : c[i];
      for (int b = 63; b >= 0; b--)
        if (m[i][b]) begin
          if (b + 1 > lmax) lmax = b + 1;
          break;
        end
    end
    if (lmax == 0) begin
      n.nx = '0; n.ny = '0; n.nz = '0; n.degen = 1'b1;
      return n;
    end
    sh = 31 - lmax;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (sh >= 0) ? (m[i] << sh) : (m[i] >> (-sh));
      s = s + m[i] * m[i];
    end
    r = isqrt(s);
    for (int i = 0; i < 3; i++) begin
      x = m[i] << FRAC;
      q = (2 * x + r) / (2 * r);
      if (q > UNIT) q = UNIT;
      // sign opposite to the cross component
      o[i] = (c[i] < 0) ? comp_t'(q) : comp_t'(-q);
    end
    n.nx = o[0]; n.ny = o[1]; n.nz = o[2]; n.degen = 1'b0;
    return n;
  endfunction

  // item acceptance: record the prediction at the edge that takes the item
  always @(posedge clk_i) begin
    tri_t t;
    if (rst_ni && start && !busy) begin
      for (int i = 0; i < 9; i++) t.p[i] = vin[i];
      expected_normals.push_back(face_normal(t));
      item_taken <= 1;
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    normal_t e;
    if (rst_ni && valid_o) begin
      n_results++;
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d degen=%0b", $time,
                 normal_x_o, normal_y_o, normal_z_o, degenerate_o);
        errors++;
      end else begin
        e = expected_normals.pop_front();
        if (e.degen) n_degen++;
        if (normal_x_o !== e.nx || normal_y_o !== e.ny || normal_z_o !== e.nz ||
            degenerate_o !== e.degen) begin
          $display("%0t: mismatch expected x=%0d y=%0d z=%0d degen=%0b", $time,
                   e.nx, e.ny, e.nz, e.degen);
          $display("%0t:          actual   x=%0d y=%0d z=%0d degen=%0b", $time,
                   normal_x_o, normal_y_o, normal_z_o, degenerate_o);
          errors++;
        end
      end
    end
  end

  // called at a falling edge; random gaps first, then drive and hold until
  // taken. start stays high on return so the next item can follow at once.
  task automatic send_item(tri_t t);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 0;
      @(negedge clk_i);
    end
    start <= 1;
    item_taken <= 0;
    for (int i = 0; i < 9; i++) vin[i] <= t.p[i];
    do @(negedge clk_i); while (!item_taken);
    n_items++;
  endtask

  function automatic tri_t mk(int a0, int a1, int a2, int b0, int b1, int b2,
                              int c0, int c1, int c2);
    tri_t t;
    t.p[0] = coord_t'(a0); t.p[1] = coord_t'(a1); t.p[2] = coord_t'(a2);
    t.p[3] = coord_t'(b0); t.p[4] = coord_t'(b1); t.p[5] = coord_t'(b2);
    t.p[6] = coord_t'(c0); t.p[7] = coord_t'(c1); t.p[8] = coord_t'(c2);
    return t;
  endfunction

  function automatic normal_t nv(int x, int y, int z, bit d);
    normal_t n;
    n.nx = comp_t'(x); n.ny = comp_t'(y); n.nz = comp_t'(z); n.degen = d;
    return n;
  endfunction

  // random triangle: mostly full range, some small, some collinear
  function automatic tri_t rand_tri();
    tri_t t;
    int kind, d [3], k;
    kind = $urandom_range(9);
    if (kind < 5) begin
      for (int i = 0; i < 9; i++) t.p[i] = coord_t'($urandom);
    end else if (kind < 8) begin
      for (int i = 0; i < 9; i++)
        t.p[i] = coord_t'($signed($urandom_range(2047)) - 1024);
    end else begin
      // collinear or coincident vertices
      k = $signed($urandom_range(100)) - 50;
      for (int i = 0; i < 3; i++) begin
        t.p[i] = coord_t'($signed($urandom_range(2097151)) - 1048576);
        d[i] = $signed($urandom_range(2000)) - 1000;
        t.p[3+i] = coord_t'(t.p[i] + d[i]);
        t.p[6+i] = coord_t'(t.p[i] + k * d[i]);
      end
    end
    return t;
  endfunction

  row_t dir_rows [$];
  localparam int MAXC = 8388607;
  localparam int MINC = -8388608;

  initial begin
    row_t r;
    normal_t got;
    // directed: degenerate cases, axis normals, unit clamp, extremes
    r.has_exp = 1;
    r.t = mk(0,0,0, 0,0,0, 0,0,0);              r.e = nv(0,0,0,1); dir_rows.push_back(r);
    r.t = mk(5,6,7, 5,6,7, 5,6,7);              r.e = nv(0,0,0,1); dir_rows.push_back(r);
    r.t = mk(0,0,0, 256,256,256, 512,512,512);  r.e = nv(0,0,0,1); dir_rows.push_back(r);
    r.t = mk(MAXC,MAXC,MAXC, MINC,MINC,MINC, MAXC,MAXC,MAXC);
    r.e = nv(0,0,0,1); dir_rows.push_back(r);
    r.t = mk(0,0,0, 256,0,0, 0,256,0);          r.e = nv(0,0,-UNIT,0); dir_rows.push_back(r);
    r.t = mk(0,0,0, 0,256,0, 256,0,0);          r.e = nv(0,0,UNIT,0); dir_rows.push_back(r);
    r.t = mk(0,0,0, 0,1,0, 0,0,1);              r.e = nv(-UNIT,0,0,0); dir_rows.push_back(r);
    r.t = mk(0,0,0, 0,0,1, 1,0,0);              r.e = nv(0,-UNIT,0,0); dir_rows.push_back(r);
    r.has_exp = 0;
    r.t = mk(MINC,MINC,MINC, MAXC,MINC,MINC, MINC,MAXC,MINC); dir_rows.push_back(r);
    r.t = mk(MAXC,MAXC,MAXC, MINC,MAXC,MAXC, MAXC,MINC,MAXC); dir_rows.push_back(r);
    r.t = mk(MINC,MAXC,MINC, MAXC,MINC,MAXC, MINC,MINC,MAXC); dir_rows.push_back(r);
    r.t = mk(MAXC,MINC,0, MINC,MAXC,MAXC, 0,MINC,MINC);       dir_rows.push_back(r);
    r.t = mk(0,0,0, 1,1,0, 1,0,1);              dir_rows.push_back(r);
    r.t = mk(0,0,0, 1,2,3, 3,2,1);              dir_rows.push_back(r);
    r.t = mk(-1,-1,-1, 0,0,0, 1,1,2);           dir_rows.push_back(r);
    r.t = mk(0,0,0, MAXC,1,0, 1,MAXC,0);        dir_rows.push_back(r);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1;

    sender_idle_pct = 20;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].t);
      if (dir_rows[i].has_exp) begin
        got = face_normal(dir_rows[i].t);
        if (got != dir_rows[i].e) begin
          $display("%0t: row %0d predictor expected x=%0d y=%0d z=%0d d=%0b", $time, i,
                   dir_rows[i].e.nx, dir_rows[i].e.ny, dir_rows[i].e.nz, dir_rows[i].e.degen);
          $display("%0t:        predictor actual   x=%0d y=%0d z=%0d d=%0b", $time,
                   got.nx, got.ny, got.nz, got.degen);
          errors++;
        end
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 20 : (ph == 1) ? 56 : 0;
      repeat (N_RAND_PER_PHASE) send_item(rand_tri());
      // hold off until the pipeline drains
      if (ph == 0) begin
        start <= 0;
        while (expected_normals.size() != 0) @(negedge clk_i);
      end
    end

    start <= 0;
    while (expected_normals.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("covered %0d triangles, %0d normals checked, %0d degenerate", n_items,
             n_results, n_degen);
    $display("idle mixes: sender 20%%, 56%%, none; one full drain mid-run");
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
